@@ src/tccs_pkg.sv @@
package tccs_pkg;

  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int OP_W    = 2;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = CHAR_W + ATTR_W;

  // Operation codes on the request channel
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Control bytes recognized by a put
  localparam logic [CHAR_W-1:0] CH_BELL      = 8'd7;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h06;

  typedef enum logic [2:0] {
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_BACKSPACE,
    CMD_BELL,
    CMD_PUT,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CHAR_W-1:0]    ch;
    logic [INDEX_W-1:0]   cell_index;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL_COPY,
    ST_SCROLL_LAST,
    ST_SCROLL_ZERO,
    ST_SCROLL_PUT,
    ST_FINISH
  } state_t;

endpackage

@@ src/tccs_req_if.sv @@
interface tccs_req_if;
  logic                          valid;
  logic                          ready;
  logic [tccs_pkg::OP_W-1:0]     op;
  logic [tccs_pkg::CHAR_W-1:0]   ch;
  logic [tccs_pkg::INDEX_W-1:0]  cell_index;

  modport source (output valid, output op, output ch, output cell_index, input ready);
  modport sink   (input valid, input op, input ch, input cell_index, output ready);
endinterface

@@ src/tccs_rsp_if.sv @@
interface tccs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tccs_pkg::POS_W-1:0]    cursor_position;
  logic [tccs_pkg::CHAR_W-1:0]   cell_char;
  logic [tccs_pkg::ATTR_W-1:0]   cell_attr;
  logic                          scrolled;

  modport source (output valid, output cursor_position, output cell_char,
                  output cell_attr, output scrolled, input ready);
  modport sink   (input valid, input cursor_position, input cell_char,
                  input cell_attr, input scrolled, output ready);
endinterface

@@ src/tccs_front.sv @@
module tccs_front (
  tccs_req_if.sink       req,
  input  logic           q_full,
  input  logic           init_busy,
  output logic           push,
  output tccs_pkg::cmd_t cmd
);

  assign req.ready = !q_full && !init_busy;
  assign push      = req.valid && req.ready;

  always_comb begin
    cmd.ch         = req.ch;
    cmd.cell_index = req.cell_index;
    case (req.op)
      tccs_pkg::OP_PUT: begin
        case (req.ch)
          tccs_pkg::CH_NEWLINE:   cmd.kind = tccs_pkg::CMD_NEWLINE;
          tccs_pkg::CH_RETURN:    cmd.kind = tccs_pkg::CMD_RETURN;
          tccs_pkg::CH_BACKSPACE: cmd.kind = tccs_pkg::CMD_BACKSPACE;
          tccs_pkg::CH_BELL:      cmd.kind = tccs_pkg::CMD_BELL;
          default:                cmd.kind = tccs_pkg::CMD_PUT;
        endcase
      end
      tccs_pkg::OP_READ:  cmd.kind = tccs_pkg::CMD_READ;
      tccs_pkg::OP_CLEAR: cmd.kind = tccs_pkg::CMD_CLEAR;
      default:            cmd.kind = tccs_pkg::CMD_NOP;
    endcase
  end

endmodule

@@ src/tccs_queue.sv @@
module tccs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tccs_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tccs_pkg::cmd_t head
);

  tccs_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/tccs_back.sv @@
module tccs_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  tccs_pkg::cmd_t                head,
  output logic                          pop,
  input  logic [tccs_pkg::ATTR_W-1:0]   attr,
  output logic                          init_busy,
  tccs_rsp_if.source                    rsp
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int LW    = 16;

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_SRC  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [RW-1:0] ROWS_V    = RW'(ROWS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW:0]   COLS_V    = (CW + 1)'(COLUMNS);

  logic [tccs_pkg::CELL_W-1:0] mem [CELLS];
  logic [tccs_pkg::CELL_W-1:0] rdata;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [tccs_pkg::CELL_W-1:0] wdata;
  logic [AW-1:0]               raddr;

  tccs_pkg::state_t state, state_next;
  logic [AW-1:0]    scan, scan_next;
  logic [CW-1:0]    col, col_next;
  logic [RW-1:0]    row, row_next;
  logic [tccs_pkg::CHAR_W-1:0] hold_ch, hold_ch_next;
  logic [tccs_pkg::CHAR_W-1:0] pend_char, pend_char_next;
  logic [tccs_pkg::ATTR_W-1:0] pend_attr, pend_attr_next;
  logic                        pend_scrolled, pend_scrolled_next;
  logic                        read_ok, read_ok_next;

  logic                        out_valid;
  logic                        out_load;
  logic                        can_emit;
  logic [tccs_pkg::CHAR_W-1:0] out_char;
  logic [tccs_pkg::ATTR_W-1:0] out_attr;
  logic                        out_scrolled;

  logic [LW-1:0] lin_cur;
  logic [LW-1:0] lin_next;
  logic [LW-1:0] head_idx;
  logic          head_in_range;
  logic [CW:0]   col_inc;
  logic [CW-1:0] col_adv;
  logic [RW-1:0] row_inc;
  logic [RW-1:0] row_adv;

  assign init_busy = (state == tccs_pkg::ST_INIT);
  assign can_emit  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  assign lin_cur       = LW'(row) * LW'(COLUMNS) + LW'(col);
  assign lin_next      = LW'(row_next) * LW'(COLUMNS) + LW'(col_next);
  assign head_idx      = LW'(head.cell_index);
  assign head_in_range = (head_idx < LW'(CELLS));

  // Cursor after a written character: advance, wrap, saturate the row
  assign row_inc = (row < ROWS_V) ? row + RW'(1) : row;
  assign col_inc = {1'b0, col} + (CW + 1)'(1);
  always_comb begin
    if (col_inc >= COLS_V) begin
      col_adv = '0;
      row_adv = row_inc;
    end else begin
      col_adv = col_inc[CW-1:0];
      row_adv = row;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next         = state;
    scan_next          = scan;
    col_next           = col;
    row_next           = row;
    hold_ch_next       = hold_ch;
    pend_char_next     = pend_char;
    pend_attr_next     = pend_attr;
    pend_scrolled_next = pend_scrolled;
    read_ok_next       = read_ok;
    we                 = 1'b0;
    waddr              = scan;
    wdata              = '0;
    raddr              = scan + ROW_STEP;
    pop                = 1'b0;
    out_load           = 1'b0;
    out_char           = '0;
    out_attr           = '0;
    out_scrolled       = 1'b0;
    case (state)
      tccs_pkg::ST_INIT: begin
        we    = 1'b1;
        waddr = scan;
        if (scan == LAST_CELL) begin
          scan_next  = '0;
          state_next = tccs_pkg::ST_IDLE;
        end else begin
          scan_next = scan + AW'(1);
        end
      end
      tccs_pkg::ST_IDLE: begin
        raddr = head_idx[AW-1:0];
        if (head_valid) begin
          case (head.kind)
            tccs_pkg::CMD_READ: begin
              pop          = 1'b1;
              read_ok_next = head_in_range;
              state_next   = tccs_pkg::ST_READ;
            end
            tccs_pkg::CMD_CLEAR: begin
              pop        = 1'b1;
              scan_next  = '0;
              state_next = tccs_pkg::ST_CLEAR;
            end
            tccs_pkg::CMD_PUT: begin
              if (row >= ROWS_V) begin
                pop          = 1'b1;
                hold_ch_next = head.ch;
                scan_next    = '0;
                row_next     = LAST_ROW;
                state_next   = tccs_pkg::ST_SCROLL_COPY;
              end else if (can_emit) begin
                pop      = 1'b1;
                we       = 1'b1;
                waddr    = lin_cur[AW-1:0];
                wdata    = {attr, head.ch};
                col_next = col_adv;
                row_next = row_adv;
                out_load = 1'b1;
              end
            end
            tccs_pkg::CMD_NEWLINE: begin
              if (can_emit) begin
                pop      = 1'b1;
                col_next = '0;
                row_next = row_inc;
                out_load = 1'b1;
              end
            end
            tccs_pkg::CMD_RETURN: begin
              if (can_emit) begin
                pop      = 1'b1;
                col_next = '0;
                out_load = 1'b1;
              end
            end
            tccs_pkg::CMD_BACKSPACE: begin
              if (can_emit) begin
                pop = 1'b1;
                if (col != '0) begin
                  col_next = col - CW'(1);
                end
                out_load = 1'b1;
              end
            end
            default: begin
              // bell and no-op: report the cursor only
              if (can_emit) begin
                pop      = 1'b1;
                out_load = 1'b1;
              end
            end
          endcase
        end
      end
      tccs_pkg::ST_READ: begin
        pend_char_next     = read_ok ? rdata[tccs_pkg::CHAR_W-1:0] : '0;
        pend_attr_next     = read_ok ? rdata[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W] : '0;
        pend_scrolled_next = 1'b0;
        state_next         = tccs_pkg::ST_FINISH;
      end
      tccs_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = scan;
        wdata = {attr, {tccs_pkg::CHAR_W{1'b0}}};
        if (scan == LAST_CELL) begin
          col_next           = '0;
          row_next           = '0;
          pend_char_next     = '0;
          pend_attr_next     = '0;
          pend_scrolled_next = 1'b0;
          state_next         = tccs_pkg::ST_FINISH;
        end else begin
          scan_next = scan + AW'(1);
        end
      end
      tccs_pkg::ST_SCROLL_COPY: begin
        // read one row ahead, write the previous cell
        raddr     = scan + ROW_STEP;
        we        = (scan != '0);
        waddr     = scan - AW'(1);
        wdata     = rdata;
        scan_next = scan + AW'(1);
        if (scan == LAST_SRC) begin
          state_next = tccs_pkg::ST_SCROLL_LAST;
        end
      end
      tccs_pkg::ST_SCROLL_LAST: begin
        we         = 1'b1;
        waddr      = scan - AW'(1);
        wdata      = rdata;
        state_next = tccs_pkg::ST_SCROLL_ZERO;
      end
      tccs_pkg::ST_SCROLL_ZERO: begin
        we    = 1'b1;
        waddr = scan;
        if (scan == LAST_CELL) begin
          state_next = tccs_pkg::ST_SCROLL_PUT;
        end else begin
          scan_next = scan + AW'(1);
        end
      end
      tccs_pkg::ST_SCROLL_PUT: begin
        we                 = 1'b1;
        waddr              = lin_cur[AW-1:0];
        wdata              = {attr, hold_ch};
        col_next           = col_adv;
        row_next           = row_adv;
        pend_char_next     = '0;
        pend_attr_next     = '0;
        pend_scrolled_next = 1'b1;
        state_next         = tccs_pkg::ST_FINISH;
      end
      tccs_pkg::ST_FINISH: begin
        if (can_emit) begin
          out_load     = 1'b1;
          out_char     = pend_char;
          out_attr     = pend_attr;
          out_scrolled = pend_scrolled;
          state_next   = tccs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tccs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tccs_pkg::ST_INIT;
      scan      <= '0;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      scan  <= scan_next;
      col   <= col_next;
      row   <= row_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_ch       <= hold_ch_next;
    pend_char     <= pend_char_next;
    pend_attr     <= pend_attr_next;
    pend_scrolled <= pend_scrolled_next;
    read_ok       <= read_ok_next;
    if (out_load) begin
      rsp.cursor_position <= lin_next[tccs_pkg::POS_W-1:0];
      rsp.cell_char       <= out_char;
      rsp.cell_attr       <= out_attr;
      rsp.scrolled        <= out_scrolled;
    end
  end

endmodule

@@ src/text_console_cursor_scroll.sv @@
// Channel   Dir  Payload                                          Handshake
// req       in   op, ch, cell_index                               valid/ready
// rsp       out  cursor_position, cell_char, cell_attr, scrolled  valid/ready
// cfg       in   cfg_wr_data (text attribute)                     cfg_wr_en
//
// Control bytes, plain puts and no-ops are answered from the idle state; a read passes
// through the read and finish states (registered memory read). Clear and scroll sweep
// the store one cell per cycle through the single memory write port.
// After reset a clearing pass zeroes the memory; req is not ready until it is done,
// while configuration writes are taken as usual. A two-entry queue parts front and
// back; the result register holds a transaction until rsp.ready.
module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  tccs_req_if.sink                    req,
  tccs_rsp_if.source                  rsp,
  input  logic                        cfg_wr_en,
  input  logic [tccs_pkg::ATTR_W-1:0] cfg_wr_data
);

  logic [tccs_pkg::ATTR_W-1:0] text_attribute;

  logic           push;
  tccs_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  tccs_pkg::cmd_t head;
  logic           init_busy;

  // Hold the attribute register; software is to write it only while idle (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tccs_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      text_attribute <= cfg_wr_data;
    end
  end

  // Front: accept the transaction and decode it into a command
  tccs_front u_front (
    .req       (req),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Queue: decouple decode from execution
  tccs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: cursor, screen memory, scroll and clear sweeps, result register
  tccs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .attr       (text_attribute),
    .init_busy  (init_busy),
    .rsp        (rsp)
  );

endmodule

@@ bench/console_checker.sv @@
module console_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  tccs_req_if                         req,
  tccs_rsp_if                         rsp,
  input  logic                        cfg_wr_en,
  input  logic [tccs_pkg::ATTR_W-1:0] cfg_wr_data,
  output int                          mismatch_count,
  output int                          pending_count
);

  localparam int CELLS       = COLUMNS * ROWS;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [tccs_pkg::POS_W-1:0]  cursor_position;
    logic [tccs_pkg::CHAR_W-1:0] cell_char;
    logic [tccs_pkg::ATTR_W-1:0] cell_attr;
    logic                        scrolled;
  } console_result_t;

  // Mirror of the console: screen store, cursor and attribute register
  logic [tccs_pkg::CELL_W-1:0]  screen_model [CELLS];
  logic [$clog2(COLUMNS)-1:0]   cur_col;
  logic [$clog2(ROWS+1)-1:0]    cur_row;
  logic [tccs_pkg::ATTR_W-1:0]  attr_reg;
  console_result_t              expected_results [$];
  int                           bad_count;

  // Saturate one past the last row
  function automatic void advance_row();
    if (cur_row < ROWS) cur_row = cur_row + 1'b1;
  endfunction

  function automatic void scroll_screen();
    int i;
    for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = '0;
    cur_row = ROWS - 1;
  endfunction

  function automatic console_result_t predict_console_step(
    input logic [tccs_pkg::OP_W-1:0]    op,
    input logic [tccs_pkg::CHAR_W-1:0]  ch,
    input logic [tccs_pkg::INDEX_W-1:0] idx
  );
    console_result_t r;
    int i;
    r = '0;
    case (op)
      tccs_pkg::OP_PUT: begin
        if (ch == tccs_pkg::CH_NEWLINE) begin
          cur_col = '0;
          advance_row();
        end else if (ch == tccs_pkg::CH_RETURN) begin
          cur_col = '0;
        end else if (ch == tccs_pkg::CH_BACKSPACE) begin
          if (cur_col != 0) cur_col = cur_col - 1'b1;
        end else if (ch != tccs_pkg::CH_BELL) begin
          if (cur_row >= ROWS) begin
            scroll_screen();
            r.scrolled = 1'b1;
          end
          screen_model[int'(cur_row) * COLUMNS + int'(cur_col)] = {attr_reg, ch};
          if (cur_col == COLUMNS - 1) begin
            cur_col = '0;
            advance_row();
          end else begin
            cur_col = cur_col + 1'b1;
          end
        end
      end
      tccs_pkg::OP_READ: begin
        if (idx < CELLS) begin
          r.cell_char = screen_model[idx][tccs_pkg::CHAR_W-1:0];
          r.cell_attr = screen_model[idx][tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W];
        end
      end
      tccs_pkg::OP_CLEAR: begin
        for (i = 0; i < CELLS; i++)
          screen_model[i] = {attr_reg, {tccs_pkg::CHAR_W{1'b0}}};
        cur_col = '0;
        cur_row = '0;
      end
      default: ;
    endcase
    r.cursor_position = tccs_pkg::POS_W'(int'(cur_row) * COLUMNS + int'(cur_col));
    return r;
  endfunction

  always @(posedge clk) begin : watch
    console_result_t got;
    console_result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < CELLS; i++) screen_model[i] = '0;
      cur_col   = '0;
      cur_row   = '0;
      attr_reg  = tccs_pkg::ATTR_RESET;
      bad_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) attr_reg = cfg_wr_data;
      if (req.valid && req.ready)
        expected_results.push_back(predict_console_step(req.op, req.ch, req.cell_index));
      if (rsp.valid && rsp.ready) begin
        got.cursor_position = rsp.cursor_position;
        got.cell_char       = rsp.cell_char;
        got.cell_attr       = rsp.cell_attr;
        got.scrolled        = rsp.scrolled;
        if (expected_results.size() == 0) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS)
            $display("unexpected response: pos %0d char %h attr %h scrolled %b",
                     got.cursor_position, got.cell_char, got.cell_attr, got.scrolled);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            bad_count++;
            if (bad_count <= MAX_REPORTS)
              $display("mismatch: pos %0d/%0d char %h/%h attr %h/%h scrolled %b/%b (exp/act)",
                       want.cursor_position, got.cursor_position,
                       want.cell_char, got.cell_char,
                       want.cell_attr, got.cell_attr,
                       want.scrolled, got.scrolled);
          end
        end
      end
    end
    mismatch_count <= bad_count;
    pending_count  <= expected_results.size();
  end

endmodule

@@ bench/tb.sv @@
module tb;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  // Op code 3 has no meaning in the block: it only reports the cursor
  localparam logic [tccs_pkg::OP_W-1:0] OP_NOP = 2'd3;
  localparam int PHASE_ITEMS = 425;
  localparam int TAIL_CYCLES = 64;
  // A scroll or a clear walks the whole store; the limit leaves several times
  // the run in which every transaction is such a sweep, plus the clearing
  // pass after reset and all random stalls.
  localparam int CYCLE_LIMIT = 20_000_000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [tccs_pkg::ATTR_W-1:0] cfg_wr_data;

  int mismatch_count;
  int pending_count;
  int src_idle_pct;
  int sink_stall_pct;
  int items_sent;
  int cycle_count = 0;

  tccs_req_if req_ch ();
  tccs_rsp_if rsp_ch ();

  text_console_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Watch both channels and the register port; predict and compare there
  console_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) checker_inst (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the response side at the rate of the current phase
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_cursor_scroll verification failed");
      $finish;
    end
  end

  // Offer one transaction and hold it until the block takes it. Valid stays
  // high afterwards so back-to-back transactions never toggle it in one step;
  // it drops only when an idle gap opens or the sender drains.
  task automatic send_item(input logic [tccs_pkg::OP_W-1:0] op,
                           input logic [tccs_pkg::CHAR_W-1:0] ch,
                           input logic [tccs_pkg::INDEX_W-1:0] idx);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.ch         <= ch;
    req_ch.cell_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic put_char(input logic [tccs_pkg::CHAR_W-1:0] ch);
    send_item(tccs_pkg::OP_PUT, ch, tccs_pkg::INDEX_W'($urandom));
  endtask

  task automatic read_cell(input logic [tccs_pkg::INDEX_W-1:0] idx);
    send_item(tccs_pkg::OP_READ, tccs_pkg::CHAR_W'($urandom), idx);
  endtask

  // Drop valid and hold off until every expected response is back. The
  // pending count is sampled on the falling edge to stay clear of the
  // checker's update on the rising edge.
  task automatic drain;
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Write the attribute register only while the block is idle
  task automatic write_attribute(input logic [tccs_pkg::ATTR_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly inside the screen, sometimes past its end (reads back zero)
  function automatic logic [tccs_pkg::INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 85)
      return tccs_pkg::INDEX_W'($urandom_range(0, CELLS - 1));
    return tccs_pkg::INDEX_W'($urandom_range(CELLS, (1 << tccs_pkg::INDEX_W) - 1));
  endfunction

  // One line of text with random content: mostly random bytes, mixed with
  // reads, backspaces, bells and no-ops, ended by a newline most of the time.
  // Long lines wrap; newlines at the bottom row drive the scroll path.
  task automatic send_text_line;
    int len;
    int k;
    int r;
    int n;
    len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12) : $urandom_range(60, 170);
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 72)      put_char(tccs_pkg::CHAR_W'($urandom));
      else if (r < 86) read_cell(pick_index());
      else if (r < 91) put_char(tccs_pkg::CH_BACKSPACE);
      else if (r < 93) put_char(tccs_pkg::CH_BELL);
      else if (r < 95) send_item(OP_NOP, tccs_pkg::CHAR_W'($urandom),
                                 tccs_pkg::INDEX_W'($urandom));
      else             put_char(tccs_pkg::CHAR_W'($urandom));
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      put_char(tccs_pkg::CH_NEWLINE);
    end else if (r < 82) begin
      put_char(tccs_pkg::CH_RETURN);
    end else if (r < 94) begin
      // Several newlines in a row push the row into saturation
      n = $urandom_range(2, 4);
      for (k = 0; k < n; k++) put_char(tccs_pkg::CH_NEWLINE);
    end else if (r < 97) begin
      send_item(tccs_pkg::OP_CLEAR, tccs_pkg::CHAR_W'($urandom),
                tccs_pkg::INDEX_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int p;
    int phase_start;
    bit paused;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= tccs_pkg::OP_PUT;
    req_ch.ch         <= '0;
    req_ch.cell_index <= '0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    rst               <= 1'b1;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    items_sent     = 0;
    paused         = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset attribute first
    read_cell('0);                 // store is zero after reset
    put_char(8'h41);
    read_cell('0);
    put_char(8'hFF);
    put_char(8'h00);               // byte zero is an ordinary character
    put_char(tccs_pkg::CH_BACKSPACE);
    put_char(tccs_pkg::CH_BELL);
    put_char(tccs_pkg::CH_RETURN);
    put_char(tccs_pkg::CH_BACKSPACE);   // backspace at column zero stays put
    put_char(tccs_pkg::CH_NEWLINE);
    put_char(8'h7F);
    read_cell(tccs_pkg::INDEX_W'(COLUMNS));
    read_cell(tccs_pkg::INDEX_W'(CELLS - 1));
    read_cell(tccs_pkg::INDEX_W'(CELLS));    // first index past the screen
    read_cell('1);
    send_item(OP_NOP, '1, '1);
    send_item(tccs_pkg::OP_CLEAR, '0, '0);
    read_cell('0);
    write_attribute(8'hFF);
    put_char(8'h80);
    read_cell('0);
    write_attribute(8'h00);
    send_item(tccs_pkg::OP_CLEAR, '1, '1);
    read_cell(tccs_pkg::INDEX_W'(CELLS - 1));
    put_char(8'h55);

    // Random part in four idling phases, one attribute setting each
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_idle_pct = 0;  sink_stall_pct = 0;
          write_attribute(tccs_pkg::ATTR_W'($urandom));
        end
        1: begin
          src_idle_pct = 59; sink_stall_pct = 0;
          write_attribute(8'hFF);
        end
        2: begin
          src_idle_pct = 0;  sink_stall_pct = 59;
          write_attribute(8'h00);
        end
        default: begin
          src_idle_pct = 25; sink_stall_pct = 25;
          write_attribute(tccs_pkg::ATTR_W'($urandom));
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // Pause the sender once until the block has answered everything
        if (p == 1 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        send_text_line();
      end
    end

    // Let the last responses out, then watch for strays
    drain();
    sink_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0)
      $display("text_console_cursor_scroll verification clean");
    else
      $display("text_console_cursor_scroll verification failed");
    $finish;
  end

endmodule
